### rtl/core/bgai_pkg.sv
// shared types, constants and curve tables for the battery gauge
// no dependencies; imported by every module of the block but bgai_sdiv
package bgai_pkg;

  localparam int unsigned SAMPLES_DEFAULT = 16;

  localparam int unsigned RAW_W       = 12;
  localparam int unsigned MV_W        = 12;
  localparam int unsigned PROD_W      = 24;
  localparam int unsigned PIN_W       = 13;
  localparam int unsigned CELL_W      = 14;
  localparam int unsigned PCT_W       = 8;
  localparam int unsigned CMV_W       = 13;
  localparam int unsigned SEG_W       = 4;
  localparam int unsigned SPAN_W      = 8;
  localparam int unsigned INTERP_W    = 12;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam int unsigned FULL_SCALE_MV   = 3300;
  localparam int unsigned FULL_SCALE_CODE = 4095;
  localparam int unsigned THR_RESET       = 150;
  localparam int unsigned CURVE_POINTS    = 12;

  localparam logic [PCT_W-1:0] PCT_NONE = '1;
  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_EN  = 2'd0,
    REG_CHG_THR = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_AVG_GO,
    ST_AVG,
    ST_SEG,
    ST_INTERP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic done;
    logic last;
  } acc_ctl_t;

  // discharge curve, highest point first
  function automatic logic [CMV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [CMV_W-1:0] v;
    unique case (idx)
      4'd0:    v = 13'd4200;
      4'd1:    v = 13'd4100;
      4'd2:    v = 13'd4000;
      4'd3:    v = 13'd3900;
      4'd4:    v = 13'd3800;
      4'd5:    v = 13'd3700;
      4'd6:    v = 13'd3600;
      4'd7:    v = 13'd3500;
      4'd8:    v = 13'd3400;
      4'd9:    v = 13'd3300;
      4'd10:   v = 13'd3200;
      default: v = 13'd3000;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
    logic [PCT_W-1:0] v;
    unique case (idx)
      4'd0:    v = 8'd100;
      4'd1:    v = 8'd90;
      4'd2:    v = 8'd80;
      4'd3:    v = 8'd70;
      4'd4:    v = 8'd60;
      4'd5:    v = 8'd50;
      4'd6:    v = 8'd37;
      4'd7:    v = 8'd25;
      4'd8:    v = 8'd15;
      4'd9:    v = 8'd8;
      4'd10:   v = 8'd3;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/bgai_acc.sv
// sample conversion and accumulation: raw code to millivolts, running sum,
// good-sample and attempt counters; uses bgai_pkg
module bgai_acc #(
  parameter int unsigned SAMPLES = bgai_pkg::SAMPLES_DEFAULT,
  parameter int unsigned SUM_W   = 16,
  parameter int unsigned CNT_W   = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic                        clear_i,
  input  logic                        cal_en_i,
  input  logic                        read_ok_i,
  input  logic [bgai_pkg::RAW_W-1:0]  raw_code_i,
  input  logic                        cal_ok_i,
  input  logic [bgai_pkg::MV_W-1:0]   cal_mv_i,
  output bgai_pkg::acc_ctl_t          ctl_o,
  output logic [SUM_W-1:0]            sum_o,
  output logic [CNT_W-1:0]            good_o
);
  import bgai_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [MV_W-1:0]   cal_mv_q;
  logic              use_cal_q, ok_q, stage_vld_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  good_q, good_d, att_q, att_d;
  logic [MV_W-1:0]   q0, mv_lin, mv_sel;
  logic [MV_W:0]     rem;

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      prod_q    <= PROD_W'(raw_code_i) * PROD_W'(FULL_SCALE_MV);
      cal_mv_q  <= cal_mv_i;
      use_cal_q <= cal_en_i & cal_ok_i;
      ok_q      <= read_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      sum_q       <= '0;
      good_q      <= '0;
      att_q       <= '0;
    end else begin
      stage_vld_q <= take_i;
      sum_q       <= sum_d;
      good_q      <= good_d;
      att_q       <= att_d;
    end
  end

  // x/4095 = q0 + carry, with q0 = x>>12 and the remainder below 2*4095
  always_comb begin
    q0     = prod_q[PROD_W-1 -: MV_W];
    rem    = {1'b0, prod_q[MV_W-1:0]} + {1'b0, q0};
    mv_lin = q0 + MV_W'(rem >= (MV_W+1)'(FULL_SCALE_CODE));
    mv_sel = use_cal_q ? cal_mv_q : mv_lin;
  end

  always_comb begin
    sum_d  = sum_q;
    good_d = good_q;
    att_d  = att_q;
    if (clear_i) begin
      sum_d  = '0;
      good_d = '0;
      att_d  = '0;
    end else if (stage_vld_q) begin
      att_d = att_q + CNT_W'(1);
      if (ok_q) begin
        sum_d  = sum_q + SUM_W'(mv_sel);
        good_d = good_q + CNT_W'(1);
      end
    end
  end

  assign ctl_o.done = stage_vld_q;
  assign ctl_o.last = (att_q == CNT_W'(SAMPLES - 1));
  assign sum_o      = sum_q;
  assign good_o     = good_q;

endmodule

### rtl/core/bgai_sdiv.sv
// restoring divider, one quotient bit per cycle through a shift register
// standalone, no package dependency
module bgai_sdiv #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DVS_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [DVS_W:0]   partial, diff;
  logic             ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  always_comb begin
    partial = {rem_q, quo_q[DVD_W-1]};
    diff    = partial - {1'b0, dvs_q};
    ge      = ~diff[DVS_W];
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CW'(DVD_W);
      run_d = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? diff[DVS_W-1:0] : partial[DVS_W-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/core/battery_gauge_average_interpolate.sv
// battery gauge top level: sample accumulation, serial averaging and
// piecewise-linear percent lookup; uses bgai_pkg, bgai_acc, bgai_sdiv
//
// input channel (in_valid_i / in_stall_o): one item per adc sample attempt,
//   taken on a clock edge with in_valid_i high and in_stall_o low
// output channel (out_valid_o / out_stall_i): one reading every
//   SAMPLES_PER_READING items, held in an output register until taken
// config channel (cfg_valid_i / cfg_ready_o): index 0 calibration enable,
//   index 1 charge threshold; unknown indices are dropped; always ready
// timing: an item that does not close a reading occupies the block for a
//   capture step and then a convert-and-accumulate step
// the closing item adds the averaging divide and the curve divide, both in
//   the shared bit-serial divider, plus the control states ST_AVG_GO,
//   ST_SEG and ST_FIN
// both divides are skipped when no sample succeeded, the second divide when
//   the result is charging or off either end of the curve
// reset: accumulators and counters clear, threshold returns to 150 mV,
//   calibration off, no reading pending
// when the receiver stalls, a finished reading waits in the output
//   register; new items are still taken until the next reading completes
module battery_gauge_average_interpolate #(
  parameter int unsigned SAMPLES_PER_READING = bgai_pkg::SAMPLES_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample attempts
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              read_ok_i,
  input  logic [bgai_pkg::RAW_W-1:0]        raw_code_i,
  input  logic                              cal_ok_i,
  input  logic [bgai_pkg::MV_W-1:0]         cal_mv_i,
  // readings
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [bgai_pkg::PIN_W-1:0] pin_mv_o,
  output logic signed [bgai_pkg::CELL_W-1:0] cell_mv_out_o,
  output logic                              charging_o,
  output logic signed [bgai_pkg::PCT_W-1:0] percent_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bgai_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bgai_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bgai_pkg::*;

  // sum of up to SAMPLES_PER_READING 12-bit values, counters hold the count
  localparam int unsigned SUM_W = $clog2(FULL_SCALE_CODE * SAMPLES_PER_READING + 1);
  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam int unsigned DIV_W = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;

  state_e state_q, state_d;

  // configuration
  logic              cal_en_q;
  logic [MV_W-1:0]   thr_q;

  // accumulator and divider hookup
  acc_ctl_t          acc_ctl;
  logic              in_take, acc_clear;
  logic [SUM_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  acc_good;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_dividend, div_quo;
  logic [DIV_W-1:0]  div_divisor;

  // reading under construction
  logic [MV_W-1:0]   avg_q;
  logic              no_sample_q, charging_q, interp_q;
  logic [PCT_W-1:0]  pct_fixed_q, base_q;

  // curve segment search
  logic [CMV_W-1:0]  cell_mv;
  logic [SEG_W-1:0]  seg;
  logic [CMV_W-1:0]  seg_lo;
  logic [SPAN_W-1:0] span_mv, delta;
  logic [PCT_W-1:0]  pct_step;
  logic [INTERP_W-1:0] interp_num;
  logic              is_charging, on_curve;

  // output register
  logic              out_valid_q, out_load;
  logic [PIN_W-1:0]  pin_q;
  logic [CELL_W-1:0] cell_q;
  logic              chg_out_q;
  logic [PCT_W-1:0]  pct_q, pct_final;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_en_q <= 1'b0;
      thr_q    <= MV_W'(THR_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CAL_EN:  cal_en_q <= cfg_data_i[0];
        REG_CHG_THR: thr_q    <= cfg_data_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  bgai_acc #(
    .SAMPLES (SAMPLES_PER_READING),
    .SUM_W   (SUM_W),
    .CNT_W   (CNT_W)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (in_take),
    .clear_i    (acc_clear),
    .cal_en_i   (cal_en_q),
    .read_ok_i  (read_ok_i),
    .raw_code_i (raw_code_i),
    .cal_ok_i   (cal_ok_i),
    .cal_mv_i   (cal_mv_i),
    .ctl_o      (acc_ctl),
    .sum_o      (acc_sum),
    .good_o     (acc_good)
  );

  bgai_sdiv #(
    .DVD_W (SUM_W),
    .DVS_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // segment lookup: the lowest-numbered point after the first at or below the cell voltage
  always_comb begin
    cell_mv = {avg_q, 1'b0};
    seg     = SEG_W'(CURVE_POINTS - 1);
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (cell_mv >= curve_mv(SEG_W'(i))) begin
        seg = SEG_W'(i);
      end
    end
    seg_lo      = curve_mv(seg);
    span_mv     = SPAN_W'(curve_mv(seg - SEG_W'(1)) - seg_lo);
    pct_step    = curve_pct(seg - SEG_W'(1)) - curve_pct(seg);
    delta       = SPAN_W'(cell_mv - seg_lo);
    interp_num  = INTERP_W'(pct_step[SEG_W-1:0] * delta);
    is_charging = avg_q < thr_q;
    // strictly above the bottom point and not above the top point
    on_curve    = !is_charging && cell_mv <= curve_mv(SEG_W'(0)) &&
                  cell_mv > curve_mv(SEG_W'(CURVE_POINTS - 1));
  end

  assign pct_final = interp_q ? (base_q + div_quo[PCT_W-1:0]) : pct_fixed_q;
  assign out_load  = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    acc_clear    = 1'b0;
    div_start    = 1'b0;
    div_dividend = acc_sum;
    div_divisor  = DIV_W'(acc_good);
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) state_d = ST_CONV;
      end
      ST_CONV: begin
        state_d = acc_ctl.last ? ST_AVG_GO : ST_IDLE;
      end
      ST_AVG_GO: begin
        // sum is latched by the divider, so the accumulator may clear now
        acc_clear = 1'b1;
        if (acc_good == '0) begin
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_AVG;
        end
      end
      ST_AVG: begin
        if (div_done) state_d = ST_SEG;
      end
      ST_SEG: begin
        div_dividend = SUM_W'(interp_num);
        div_divisor  = DIV_W'(span_mv);
        if (on_curve) begin
          div_start = 1'b1;
          state_d   = ST_INTERP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_INTERP: begin
        if (div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // reading under construction
  always_ff @(posedge clk_i) begin
    if (state_q == ST_AVG_GO) begin
      no_sample_q <= (acc_good == '0);
      interp_q    <= 1'b0;
    end
    if (state_q == ST_AVG && div_done) begin
      avg_q <= div_quo[MV_W-1:0];
    end
    if (state_q == ST_SEG) begin
      charging_q <= is_charging;
      base_q     <= curve_pct(seg);
      interp_q   <= on_curve;
      // fixed percent only matters off the curve or while charging
      if (!is_charging && cell_mv > curve_mv(SEG_W'(0))) begin
        pct_fixed_q <= PCT_FULL;
      end else begin
        pct_fixed_q <= PCT_NONE;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (no_sample_q) begin
        pin_q     <= '1;
        cell_q    <= '1;
        chg_out_q <= 1'b0;
        pct_q     <= PCT_NONE;
      end else begin
        pin_q     <= PIN_W'(avg_q);
        cell_q    <= CELL_W'({avg_q, 1'b0});
        chg_out_q <= charging_q;
        pct_q     <= pct_final;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pin_mv_o      = pin_q;
  assign cell_mv_out_o = cell_q;
  assign charging_o    = chg_out_q;
  assign percent_o     = pct_q;

endmodule

### rtl/core/bgai_chk.sv
// port-level checks for the battery gauge top level, bound to every instance
// depends on battery_gauge_average_interpolate's port list and bgai_pkg
module bgai_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               read_ok_i,
  input logic [bgai_pkg::RAW_W-1:0]         raw_code_i,
  input logic                               cal_ok_i,
  input logic [bgai_pkg::MV_W-1:0]          cal_mv_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [bgai_pkg::PIN_W-1:0]  pin_mv_o,
  input logic signed [bgai_pkg::CELL_W-1:0] cell_mv_out_o,
  input logic                               charging_o,
  input logic signed [bgai_pkg::PCT_W-1:0]  percent_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [bgai_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input logic [bgai_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bgai_pkg::*;

  // a stalled reading holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pin_mv_o) &&
    $stable(cell_mv_out_o) && $stable(charging_o) && $stable(percent_o))
    else $error("stalled reading changed");

  // an accepted item keeps the block busy for its conversion cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before conversion");

  // a reading with no good sample is all minus one and not charging
  a_no_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pin_mv_o == '1 |->
    cell_mv_out_o == '1 && !charging_o && percent_o == PCT_NONE)
    else $error("no-sample reading inconsistent");

  // charging readings carry no percent and a cell voltage of twice the pin voltage
  a_charging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && charging_o |->
    percent_o == PCT_NONE && cell_mv_out_o == {pin_mv_o, 1'b0})
    else $error("charging reading inconsistent");

endmodule

bind battery_gauge_average_interpolate bgai_chk u_bgai_chk (.*);
